@@ rtl/mmwds_pkg.sv @@
// ----------------------------------------------------------------------------
// mmwds_pkg
// Shared types, codes and constants of the module watchdog supervisor.
// ----------------------------------------------------------------------------
package mmwds_pkg;

	localparam int MODULES      = 8;
	localparam int MOD_W        = 3;
	localparam int TIME_W       = 32;
	localparam int NUM_DEFAULTS = 6;
	localparam int DEF_W        = $clog2(NUM_DEFAULTS);
	localparam int IN_W         = 48;
	localparam int OUT_W        = 72;

	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_HEART    = 3'd1;
	localparam logic [2:0] CMD_PROGRESS = 3'd2;
	localparam logic [2:0] CMD_BEGIN    = 3'd3;
	localparam logic [2:0] CMD_END      = 3'd4;
	localparam logic [2:0] CMD_MODE     = 3'd5;
	localparam logic [2:0] CMD_CHECK    = 3'd6;

	localparam logic [2:0] MODE_BOOT     = 3'd0;
	localparam logic [2:0] MODE_ACTIVE   = 3'd1;
	localparam logic [2:0] MODE_SLEEP    = 3'd2;
	localparam logic [2:0] MODE_LONG     = 3'd3;
	localparam logic [2:0] MODE_SHUTDOWN = 3'd4;

	localparam logic [2:0] REG_REQUIRED_MASK = 3'd0;
	localparam logic [2:0] REG_TIMEOUT_FIRST = 3'd1;

	localparam logic [7:0] REQUIRED_MASK_RESET = 8'd1;

	localparam logic [TIME_W-1:0] DEFAULT_RESET [NUM_DEFAULTS] = '{
		TIME_W'(10000), TIME_W'(20000), TIME_W'(180000),
		TIME_W'(20000), TIME_W'(10000), TIME_W'(60000)
	};

	typedef struct packed {
		logic [5:0]        pad;
		logic              hw_enabled;
		logic [2:0]        new_mode;
		logic [TIME_W-1:0] task_tmo;
		logic [MOD_W-1:0]  module_req;
		logic [2:0]        cmd;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        mode_at_check;
		logic [TIME_W-1:0] failed_age;
		logic [TIME_W-1:0] failed_last;
		logic [MOD_W-1:0]  fail_idx;
		logic              failed;
		logic              pet;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] hb;
		logic [TIME_W-1:0] pr;
		logic [TIME_W-1:0] tt;
	} entry_t;

	typedef struct packed {
		logic              hit;
		logic [TIME_W-1:0] last;
		logic [TIME_W-1:0] age;
	} eval_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WR   = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

@@ rtl/mmwds_eval.sv @@
// ----------------------------------------------------------------------------
// mmwds_eval
// Judge one module entry during a check scan: selection, age and timeout.
// ----------------------------------------------------------------------------
module mmwds_eval
	import mmwds_pkg::*;
(
	input  logic              act,
	input  logic              req_bit,
	input  logic              task_bit,
	input  entry_t            ent,
	input  logic              ent_ok,
	input  logic [TIME_W-1:0] now,
	input  logic [TIME_W-1:0] dflt,
	output eval_t             res
);

	logic              sel;
	logic [TIME_W-1:0] last;
	logic [TIME_W-1:0] lim;
	logic [TIME_W-1:0] age;
	logic              never;

	always_comb begin
		sel   = act ? req_bit : task_bit;
		last  = ent_ok ? (act ? ent.hb : ent.pr) : '0;
		lim   = act ? dflt : (ent_ok ? ent.tt : '0);
		age   = now - last;
		never = (last == '0);
		res.hit  = sel && (never || (lim != '0 && age > lim));
		res.last = last;
		res.age  = never ? '0 : age;
	end

endmodule

@@ rtl/multi_module_watchdog_supervisor_unit.sv @@
// Tick and set mode take effect on acceptance; heartbeat, progress, begin and end
// pass through a write state (read then write of the module entry memory). A check
// without a scan goes straight to the emit state; a scan reads one entry per cycle
// through the single memory port until the first failure or the last module, then emits.
// Throughput: one item at a time; a waiting result does not block non-check items.
// Reset clears time, mode, task flags, entry valid bits and control state; no clearing pass.
// ----------------------------------------------------------------------------
// multi_module_watchdog_supervisor_unit
// Heartbeat watchdog supervisor for eight modules with an entry memory.
// ----------------------------------------------------------------------------
module multi_module_watchdog_supervisor_unit
	import mmwds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// cmd, module_req, task_tmo, new_mode, hw_enabled, zero fill
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// pet, failed, fail_idx, failed_last, failed_age, mode_at_check
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [TIME_W-1:0] cfg_wdata
);

	state_t             state_q;
	in_item_t           in_item;
	logic               accept;
	logic [7:0]         req_mask_q;
	logic [TIME_W-1:0]  dflt_q [NUM_DEFAULTS];
	logic [TIME_W-1:0]  now_q;
	logic [2:0]         mode_q;
	logic [MODULES-1:0] task_q;
	logic [MODULES-1:0] valid_q;
	logic [2:0]         cmd_q;
	logic [MOD_W-1:0]   mod_q;
	logic [TIME_W-1:0]  tmo_q;
	entry_t             mem [MODULES];
	entry_t             rd_s1;
	logic               rd_ok_s1;
	logic               vld_s1;
	logic [MOD_W-1:0]   idx_s1;
	logic [MOD_W-1:0]   scan_q;
	logic [MOD_W-1:0]   rd_addr;
	logic               mem_we;
	entry_t             wr_ent;
	logic [MOD_W-1:0]   def_idx;
	logic [TIME_W-1:0]  def_to;
	eval_t              ev;
	out_item_t          pend_q;
	out_item_t          out_q;
	logic               out_vld_q;
	logic               emit_go;
	logic               scan_end;
	logic               scan_mode;

	assign in_item   = in_item_t'(s_tdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;
	assign emit_go   = (state_q == ST_EMIT) && (!out_vld_q || m_tready);
	assign scan_mode = (mode_q == MODE_ACTIVE) || (mode_q == MODE_LONG);
	assign rd_addr   = (state_q == ST_SCAN) ? scan_q : in_item.module_req;
	assign def_idx   = (state_q == ST_SCAN) ? idx_s1 : mod_q;
	assign scan_end  = vld_s1 && (ev.hit || idx_s1 == MOD_W'(MODULES - 1));

	always_comb begin
		if (def_idx < MOD_W'(NUM_DEFAULTS)) begin
			def_to = dflt_q[DEF_W'(def_idx)];
		end else begin
			def_to = '0;
		end
	end

	always_comb begin
		wr_ent = rd_ok_s1 ? rd_s1 : '0;
		mem_we = (state_q == ST_WR);
		case (cmd_q)
			CMD_HEART: begin
				wr_ent.hb = now_q;
			end
			CMD_PROGRESS: begin
				wr_ent.hb = now_q;
				wr_ent.pr = now_q;
			end
			CMD_BEGIN: begin
				wr_ent.hb = now_q;
				wr_ent.pr = now_q;
				wr_ent.tt = (tmo_q == '0) ? def_to : tmo_q;
			end
			CMD_END: begin
				wr_ent.tt = '0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mod_q] <= wr_ent;
		end
		rd_s1 <= mem[rd_addr];
	end

	mmwds_eval u_eval (
		.act      (mode_q == MODE_ACTIVE),
		.req_bit  (req_mask_q[idx_s1]),
		.task_bit (task_q[idx_s1]),
		.ent      (rd_s1),
		.ent_ok   (rd_ok_s1),
		.now      (now_q),
		.dflt     (def_to),
		.res      (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_mask_q <= REQUIRED_MASK_RESET;
			dflt_q     <= DEFAULT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_REQUIRED_MASK) begin
				req_mask_q <= cfg_wdata[7:0];
			end else if (cfg_index <= 3'(NUM_DEFAULTS)) begin
				dflt_q[DEF_W'(cfg_index - REG_TIMEOUT_FIRST)] <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			now_q     <= '0;
			mode_q    <= MODE_BOOT;
			task_q    <= '0;
			valid_q   <= '0;
			rd_ok_s1  <= 1'b0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			scan_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_ok_s1 <= valid_q[rd_addr];
			vld_s1   <= (state_q == ST_SCAN) && !scan_end;
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_item.cmd)
							CMD_TICK: begin
								now_q <= now_q + 1'b1;
							end
							CMD_HEART, CMD_PROGRESS, CMD_BEGIN, CMD_END: begin
								state_q <= ST_WR;
							end
							CMD_MODE: begin
								if (in_item.new_mode <= MODE_SHUTDOWN) begin
									mode_q <= in_item.new_mode;
								end
							end
							CMD_CHECK: begin
								if (in_item.hw_enabled && scan_mode) begin
									state_q <= ST_SCAN;
									scan_q  <= '0;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WR: begin
					valid_q[mod_q] <= 1'b1;
					if (cmd_q == CMD_BEGIN) begin
						task_q[mod_q] <= 1'b1;
					end else if (cmd_q == CMD_END) begin
						task_q[mod_q] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_EMIT;
					end else begin
						scan_q <= scan_q + 1'b1;
						idx_s1 <= scan_q;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_item.cmd;
			mod_q  <= in_item.module_req;
			tmo_q  <= in_item.task_tmo;
			pend_q <= '{pet: in_item.hw_enabled, failed: 1'b0, fail_idx: '0,
				failed_last: '0, failed_age: '0, mode_at_check: mode_q};
		end else if (state_q == ST_SCAN && scan_end) begin
			pend_q <= '{pet: !ev.hit, failed: ev.hit,
				fail_idx: ev.hit ? idx_s1 : pend_q.fail_idx,
				failed_last: ev.hit ? ev.last : pend_q.failed_last,
				failed_age: ev.hit ? ev.age : pend_q.failed_age,
				mode_at_check: pend_q.mode_at_check};
		end
		if (emit_go) begin
			out_q <= pend_q;
		end
	end

endmodule

@@ rtl/mmwds_checker.sv @@
// ----------------------------------------------------------------------------
// mmwds_checker
// Port-level checks of the watchdog supervisor results, bound to the top level.
// ----------------------------------------------------------------------------
module mmwds_checker
	import mmwds_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_W-1:0]  m_tdata
);

	out_item_t res;

	assign res = out_item_t'(m_tdata);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_pet_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.pet && res.failed))
		else $error("pet and failed both set");

	a_clean_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.failed |-> res.fail_idx == '0 && res.failed_last == '0
			&& res.failed_age == '0)
		else $error("failure fields set without failure");

	a_fail_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.failed |-> res.mode_at_check == MODE_ACTIVE
			|| res.mode_at_check == MODE_LONG)
		else $error("failure reported outside a scanning mode");

	a_never_age: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.failed_last == '0 |-> res.failed_age == '0)
		else $error("age reported for a never seen module");

endmodule

bind multi_module_watchdog_supervisor_unit mmwds_checker u_mmwds_checker (.*);
